// ===== hw/rtl/bb3_pkg.sv =====
// shared types and constants of the 3x3 box blur stream block
package bb3_pkg;

    // sample and arithmetic widths
    localparam int PIX_W      = 8;
    localparam int NUM_CHAN   = 4;
    localparam int TAPS       = 9;
    localparam int SUM_W      = 12;
    localparam int WEIGHT_W   = 16;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = SUM_W + WEIGHT_W;
    localparam int PIX_MAX    = 255;

    // geometry
    localparam int COL_OUT_W  = 11;
    localparam int ROW_W      = 12;
    localparam int FW_W       = 12;
    localparam int FH_W       = 13;
    localparam int CMP_W      = 14;
    localparam int DIM_MIN    = 3;
    localparam int HEIGHT_MAX = 4096;

    // configuration
    localparam int CH_CNT_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_WEIGHT    = 2'd3;

    // output buffer
    localparam int OUT_DEPTH  = 8;
    localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W  = $clog2(OUT_DEPTH + 1);
    localparam int IN_DATA_W  = NUM_CHAN * PIX_W;
    localparam int OUT_DATA_W = 56;

    // position and flags of a word on its way through the pipeline
    typedef struct packed {
        logic                 valid;
        logic [COL_OUT_W-1:0] column;
        logic [ROW_W-1:0]     row;
        logic                 last;
    } bb3_side_t;

endpackage

// ===== hw/rtl/bb3_ram.sv =====
// generic single-write, single-read ram with registered read data
module bb3_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hw/rtl/bb3_lane.sv =====
// one channel lane: nine-tap sum, weight multiply, floor and saturate
module bb3_lane (
    input  logic                                   aclk,
    input  logic [bb3_pkg::TAPS-1:0][bb3_pkg::PIX_W-1:0] taps,
    input  logic [bb3_pkg::WEIGHT_W-1:0]           weight,
    input  logic                                   lane_on,
    output logic [bb3_pkg::PIX_W-1:0]              result
);
    import bb3_pkg::*;

    logic [SUM_W-1:0]  sum_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-FRAC_W-1:0] scaled;

    // add the nine taps
    always_comb begin
        sum_next = '0;
        for (int i = 0; i < TAPS; i++) begin
            sum_next = sum_next + SUM_W'(taps[i]);
        end
    end

    // sum stage, then product stage
    always_ff @(posedge aclk) begin
        sum_reg  <= sum_next;
        prod_reg <= PROD_W'(sum_reg) * PROD_W'(weight);
    end

    // drop the fraction, clamp, blank unused channels
    assign scaled = prod_reg[PROD_W-1:FRAC_W];

    always_comb begin
        if (!lane_on) begin
            result = '0;
        end else if (scaled > (PROD_W-FRAC_W)'(PIX_MAX)) begin
            result = PIX_W'(PIX_MAX);
        end else begin
            result = scaled[PIX_W-1:0];
        end
    end

endmodule

// ===== hw/rtl/bb3_merge.sv =====
// merge of lane results with position into the output buffer and credit count
module bb3_merge (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  bb3_pkg::bb3_side_t                         side,
    input  logic [bb3_pkg::NUM_CHAN-1:0][bb3_pkg::PIX_W-1:0] chan,
    input  logic                                       reserve,
    output logic                                       has_room,
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    // m_tdata: out_chan0, out_chan1, out_chan2, out_chan3, out_column, out_row, zero pad
    output logic [bb3_pkg::OUT_DATA_W-1:0]             m_tdata,
    output logic                                       m_tlast
);
    import bb3_pkg::*;

    localparam int PAD_W = OUT_DATA_W - NUM_CHAN * PIX_W - COL_OUT_W - ROW_W;

    logic [OUT_DATA_W-1:0] data_reg [OUT_DEPTH];
    logic                  last_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]  wr_ptr_reg;
    logic [OUT_PTR_W-1:0]  rd_ptr_reg;
    logic [OUT_CNT_W-1:0]  count_reg;
    logic [OUT_CNT_W-1:0]  pending_reg;
    logic [OUT_CNT_W-1:0]  pending_next;
    logic                  push;
    logic                  pop;
    logic [OUT_DATA_W-1:0] word;

    // pack one result word
    assign word = {{PAD_W{1'b0}}, side.row, side.column, chan};

    assign push = side.valid;
    assign pop  = m_tvalid && m_tready;

    // buffer storage
    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg[wr_ptr_reg] <= word;
            last_reg[wr_ptr_reg] <= side.last;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
        end
    end

    // words promised to the buffer: accepted with a result, not yet taken
    assign pending_next = pending_reg + OUT_CNT_W'(reserve) - OUT_CNT_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    assign has_room = pending_reg < OUT_CNT_W'(OUT_DEPTH);

    assign m_tvalid = count_reg != '0;
    assign m_tdata  = data_reg[rd_ptr_reg];
    assign m_tlast  = last_reg[rd_ptr_reg];

endmodule

// ===== hw/rtl/box_blur_3x3_stream.sv =====
// top level of the 3x3 box blur over a raster pixel stream
//
//  channel | ports              | word
//  --------+--------------------+------------------------------------------
//  input   | s_tvalid/s_tready  | one pixel, four 8-bit channels
//  output  | m_tvalid/m_tready  | blurred interior pixel, column, row, tlast
//  config  | cfg_valid/cfg_ready| register index and value, always ready
//
// one pixel per clock while s_tready is high; results leave
// through an 8-word output buffer
// the two line buffers are rams read at accept and written in the following cycle
// reset is synchronous, clears counters and pipeline valids, and loads configuration defaults
// s_tready drops only when the output buffer has no unpromised space
module box_blur_3x3_stream #(
    parameter int MAX_WIDTH    = 2048,
    parameter int MAX_CHANNELS = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata: in_chan0, in_chan1, in_chan2, in_chan3
    input  logic [bb3_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata: out_chan0, out_chan1, out_chan2, out_chan3, out_column, out_row, zero pad
    output logic [bb3_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bb3_pkg::*;

    localparam int CNT_W    = $clog2(MAX_WIDTH);
    localparam int PIX_BITS = PIX_W * MAX_CHANNELS;

    // configuration registers
    logic [FW_W-1:0]     width_reg;
    logic [FH_W-1:0]     height_reg;
    logic [CH_CNT_W-1:0] chans_reg;
    logic [WEIGHT_W-1:0] weight_reg;

    // effective settings
    logic [CMP_W-1:0]    eff_w;
    logic [FH_W-1:0]     eff_h;
    logic [CH_CNT_W-1:0] eff_ch;

    // position counters
    logic [CNT_W-1:0]    col_reg;
    logic [CNT_W-1:0]    col_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;
    logic                col_end;
    logic                row_end;
    logic                accept;
    logic                emit;
    logic                has_room;
    logic [CMP_W-1:0]    col_wide;

    // first stage: ram read in flight
    logic                p0_valid_reg;
    logic [CNT_W-1:0]    p0_addr_reg;
    logic [PIX_BITS-1:0] p0_pix_reg;
    bb3_side_t           p0_side_reg;
    bb3_side_t           p0_side_next;
    bb3_side_t           p1_side_reg;
    bb3_side_t           p2_side_reg;
    bb3_side_t           p3_side_reg;

    logic [PIX_BITS-1:0] upper_rd;
    logic [PIX_BITS-1:0] middle_rd;

    // window, [row 0 oldest][column 0 oldest]
    logic [2:0][2:0][PIX_BITS-1:0] win_reg;

    logic [NUM_CHAN-1:0][PIX_W-1:0] lane_res;

    // register writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= FW_W'(640);
            height_reg <= FH_W'(480);
            chans_reg  <= CH_CNT_W'(3);
            weight_reg <= WEIGHT_W'(7209);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:   width_reg  <= cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT:  height_reg <= cfg_data[FH_W-1:0];
                CFG_CHANNEL_COUNT: chans_reg  <= cfg_data[CH_CNT_W-1:0];
                CFG_TAP_WEIGHT:    weight_reg <= cfg_data[WEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp settings into their usable ranges
    always_comb begin
        if (CMP_W'(width_reg) < CMP_W'(DIM_MIN)) begin
            eff_w = CMP_W'(DIM_MIN);
        end else if (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH)) begin
            eff_w = CMP_W'(MAX_WIDTH);
        end else begin
            eff_w = CMP_W'(width_reg);
        end
        if (height_reg < FH_W'(DIM_MIN)) begin
            eff_h = FH_W'(DIM_MIN);
        end else if (height_reg > FH_W'(HEIGHT_MAX)) begin
            eff_h = FH_W'(HEIGHT_MAX);
        end else begin
            eff_h = height_reg;
        end
        if (chans_reg > CH_CNT_W'(MAX_CHANNELS)) begin
            eff_ch = CH_CNT_W'(MAX_CHANNELS);
        end else begin
            eff_ch = chans_reg;
        end
    end

    // position tracking
    assign s_tready = has_room;
    assign accept   = s_tvalid && s_tready;
    assign col_wide = CMP_W'(col_reg);
    assign col_end  = (col_wide + CMP_W'(1)) >= eff_w;
    assign row_end  = (FH_W'(row_reg) + FH_W'(1)) >= eff_h;
    assign emit     = (row_reg >= ROW_W'(2)) && (col_wide >= CMP_W'(2));

    always_comb begin
        if (col_end) begin
            col_next = '0;
            row_next = row_end ? '0 : row_reg + 1'b1;
        end else begin
            col_next = col_reg + 1'b1;
            row_next = row_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // sideband of the pixel being taken
    always_comb begin
        p0_side_next.valid  = accept && emit;
        p0_side_next.column = COL_OUT_W'(col_wide - CMP_W'(1));
        p0_side_next.row    = row_reg - 1'b1;
        p0_side_next.last   = row_end && col_end;
    end

    // pipeline sideband
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg <= 1'b0;
            p0_side_reg  <= '0;
            p1_side_reg  <= '0;
            p2_side_reg  <= '0;
            p3_side_reg  <= '0;
        end else begin
            p0_valid_reg <= accept;
            p0_side_reg  <= p0_side_next;
            p1_side_reg  <= p0_side_reg;
            p2_side_reg  <= p1_side_reg;
            p3_side_reg  <= p2_side_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p0_addr_reg <= col_reg;
            p0_pix_reg  <= s_tdata[PIX_BITS-1:0];
        end
    end

    // line buffers: upper takes the old middle entry, middle takes the pixel
    bb3_ram #(
        .WIDTH (PIX_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .aclk    (aclk),
        .wr_en   (p0_valid_reg),
        .wr_addr (p0_addr_reg),
        .wr_data (middle_rd),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (upper_rd)
    );

    bb3_ram #(
        .WIDTH (PIX_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_middle (
        .aclk    (aclk),
        .wr_en   (p0_valid_reg),
        .wr_addr (p0_addr_reg),
        .wr_data (p0_pix_reg),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (middle_rd)
    );

    // window shift with the newest column
    always_ff @(posedge aclk) begin
        if (p0_valid_reg) begin
            for (int i = 0; i < 3; i++) begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= upper_rd;
            win_reg[1][2] <= middle_rd;
            win_reg[2][2] <= p0_pix_reg;
        end
    end

    // one lane per channel up to MAX_CHANNELS; lanes past the channel count output zero
    for (genvar k = 0; k < NUM_CHAN; k++) begin : g_lane
        if (k < MAX_CHANNELS) begin : g_on
            logic [TAPS-1:0][PIX_W-1:0] taps;

            always_comb begin
                for (int i = 0; i < 3; i++) begin
                    for (int j = 0; j < 3; j++) begin
                        taps[i*3+j] = win_reg[i][j][k*PIX_W +: PIX_W];
                    end
                end
            end

            bb3_lane u_lane (
                .aclk    (aclk),
                .taps    (taps),
                .weight  (weight_reg),
                .lane_on (CH_CNT_W'(k) < eff_ch),
                .result  (lane_res[k])
            );
        end else begin : g_off
            assign lane_res[k] = '0;
        end
    end

    // merge and output buffer
    bb3_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .side     (p3_side_reg),
        .chan     (lane_res),
        .reserve  (p0_side_next.valid),
        .has_room (has_room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
